// File: rtl/joystick_to_servo_conditioner_top_assert.svh
// Assertion macros shared by the joystick conditioner checker.
`ifndef JOYSTICK_TO_SERVO_CONDITIONER_TOP_ASSERT_SVH
`define JOYSTICK_TO_SERVO_CONDITIONER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JTS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rs)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JTS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rs)) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/jts_pkg.sv
// Types, constants and small helper functions of the joystick conditioner.
package jts_pkg;

  localparam int CAL_W   = 12;
  localparam int STEP_W  = 9;
  localparam int TRIM_W  = 8;
  localparam int PCT_W   = 8;
  localparam int MAG_W   = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN    = 3'd0,
    CFG_X_CENTER = 3'd1,
    CFG_X_MAX    = 3'd2,
    CFG_Y_MIN    = 3'd3,
    CFG_Y_CENTER = 3'd4,
    CFG_Y_MAX    = 3'd5,
    CFG_SLEW     = 3'd6,
    CFG_TRIM     = 3'd7
  } cfg_idx_t;

  localparam logic [CAL_W-1:0]  X_MIN_RST    = 12'd418;
  localparam logic [CAL_W-1:0]  X_CENTER_RST = 12'd2000;
  localparam logic [CAL_W-1:0]  X_MAX_RST    = 12'd3100;
  localparam logic [CAL_W-1:0]  Y_MIN_RST    = 12'd0;
  localparam logic [CAL_W-1:0]  Y_CENTER_RST = 12'd2000;
  localparam logic [CAL_W-1:0]  Y_MAX_RST    = 12'd3218;
  localparam logic [STEP_W-1:0] SLEW_RST     = 9'd30;
  localparam int                TRIM_RST     = -50;

  localparam int PCT_FULL     = 100;
  localparam int SNAP_HI      = 70;
  localparam int SNAP_LO      = 30;
  localparam int BOTH_TH      = 40;
  localparam int NEUTRAL_PCT  = 5;
  localparam int Y_MAX_OFF    = 150;
  localparam int PULSE_GAIN   = 5;
  localparam int PULSE_LO     = 1000;
  localparam int PULSE_MID    = 1500;
  localparam int PULSE_HI     = 2000;

  // Magnitude of a percent value in -100..100.
  function automatic logic [MAG_W-1:0] pct_mag(input logic signed [PCT_W-1:0] p);
    logic [PCT_W-1:0] a;
    a = p[PCT_W-1] ? PCT_W'(-p) : PCT_W'(p);
    return a[MAG_W-1:0];
  endfunction

  // p * 30 / 100 truncated toward zero; m*3/10 uses the reciprocal 205/2048,
  // exact for every numerator up to 300.
  function automatic logic signed [PCT_W-1:0] pct_scale30(
      input logic signed [PCT_W-1:0] p);
    logic [MAG_W-1:0] m;
    logic [8:0]       t;
    logic [15:0]      prod;
    logic [PCT_W-1:0] s;
    m    = pct_mag(p);
    t    = 9'(m) * 9'd3;
    prod = 16'(t) * 16'd205;
    s    = PCT_W'(prod[15:11]);
    return p[PCT_W-1] ? $signed(PCT_W'(-s)) : $signed(s);
  endfunction

endpackage

// File: rtl/joystick_to_servo_conditioner_top.sv
// Joystick to servo conditioner: calibrated percent mapping, cross-axis mixing and slew limiting.
//
// One input word carries a raw X and Y converter sample. Each axis is turned
// into a signed percent with its own calibrated minimum, center and maximum,
// using a single restoring divider that is shared by both axes: X is divided
// first, then Y, one quotient bit per clock. After both percents are known a
// cross-axis rule snaps or suppresses the weaker axis, each percent is mapped
// to a servo pulse (dead band around center, 1000..2000 otherwise), the Y
// offset is clamped and trimmed, and both pulses are slew-limited against the
// filter state. With W = max(ADC_BITS, 12) the divider runs W+7 steps per
// axis, using the shared bit-serial loop for X and then for Y.
// The block holds in_stall high from acceptance until the result has been
// loaded into the output register; a result that is not yet taken only delays
// the end of the following word. Configuration writes are always ready and
// must only be issued while the block is idle.
module joystick_to_servo_conditioner_top
  import jts_pkg::*;
#(
  parameter int ADC_BITS   = 12,
  parameter int PULSE_BITS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ADC_BITS-1:0]         in_raw_x,
  input  logic [ADC_BITS-1:0]         in_raw_y,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [PCT_W-1:0]     out_x_percent,
  output logic signed [PCT_W-1:0]     out_y_percent,
  output logic [PULSE_BITS-1:0]       out_x_pulse,
  output logic [PULSE_BITS-1:0]       out_y_pulse,
  // Configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CAL_W-1:0]            cfg_data
);

  // Operand width covers both the sample and the calibration registers.
  localparam int W     = (ADC_BITS > CAL_W) ? ADC_BITS : CAL_W;
  localparam int NUM_W = W + 7;              // holds |d| * 100
  localparam int CW    = $clog2(NUM_W);
  localparam int TW    = PULSE_BITS + 2;     // signed pulse arithmetic

  localparam logic [PULSE_BITS-1:0] FX_RST = PULSE_BITS'(PULSE_MID);
  localparam logic [PULSE_BITS-1:0] FY_RST = PULSE_BITS'(PULSE_MID + TRIM_RST);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_DIV, S_FIN, S_MIX, S_SLEW, S_DONE
  } state_t;

  state_t                   state_r;
  logic                     axis_r;          // 0 while X is divided, 1 for Y
  logic [CW-1:0]            cnt_r;
  logic [ADC_BITS-1:0]      raw_x_r, raw_y_r;
  logic [NUM_W-1:0]         num_r;           // dividend bits out, quotient bits in
  logic [W-1:0]             rem_r;
  logic [W-1:0]             den_r;
  logic                     neg_r;
  logic signed [PCT_W-1:0]  px_r, py_r;
  logic [PULSE_BITS-1:0]    filt_x_r, filt_y_r;
  logic                     out_valid_r;
  logic signed [PCT_W-1:0]  out_x_pct_r, out_y_pct_r;
  logic [PULSE_BITS-1:0]    out_x_pulse_r, out_y_pulse_r;

  logic [CAL_W-1:0]         x_min_r, x_center_r, x_max_r;
  logic [CAL_W-1:0]         y_min_r, y_center_r, y_max_r;
  logic [STEP_W-1:0]        slew_r;
  logic signed [TRIM_W-1:0] trim_r;

  // Operand setup for the axis being divided.
  logic [W-1:0]             raw_sel, lo_sel, mid_sel, hi_sel;
  logic signed [W:0]        diff, rng;
  logic [W:0]               diff_abs, rng_abs;
  logic [W-1:0]             den_nxt;
  logic [NUM_W-1:0]         numer_nxt;
  logic                     neg_nxt;

  always_comb begin
    raw_sel  = axis_r ? W'(raw_y_r) : W'(raw_x_r);
    lo_sel   = axis_r ? W'(y_min_r) : W'(x_min_r);
    mid_sel  = axis_r ? W'(y_center_r) : W'(x_center_r);
    hi_sel   = axis_r ? W'(y_max_r) : W'(x_max_r);
    diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, mid_sel});
    rng      = diff[W] ? $signed({1'b0, mid_sel}) - $signed({1'b0, lo_sel})
                       : $signed({1'b0, hi_sel}) - $signed({1'b0, mid_sel});
    diff_abs = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
    rng_abs  = rng[W] ? (W+1)'(-rng) : (W+1)'(rng);
    // A zero half-range divides by one: any nonzero offset then saturates.
    den_nxt  = (rng_abs[W-1:0] == '0) ? W'(1) : rng_abs[W-1:0];
    numer_nxt = NUM_W'(diff_abs[W-1:0]) * NUM_W'(PCT_FULL);
    neg_nxt  = diff[W] ^ rng[W];
  end

  // One restoring division step.
  logic [W:0]   rem_sh;
  logic         q_bit;
  logic [W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_nxt = q_bit ? W'(rem_sh - {1'b0, den_r}) : rem_sh[W-1:0];
  end

  // Clamp the quotient to 100 and apply the sign.
  logic [MAG_W-1:0]        q_mag;
  logic signed [PCT_W-1:0] pct_nxt;

  always_comb begin
    q_mag   = (num_r > NUM_W'(PCT_FULL)) ? MAG_W'(PCT_FULL) : num_r[MAG_W-1:0];
    pct_nxt = neg_r ? $signed(PCT_W'(-PCT_W'(q_mag))) : $signed(PCT_W'(q_mag));
  end

  // Cross-axis rule on the two percents.
  logic [MAG_W-1:0]        ax, ay;
  logic signed [PCT_W-1:0] mx_nxt, my_nxt;

  always_comb begin
    ax     = pct_mag(px_r);
    ay     = pct_mag(py_r);
    mx_nxt = px_r;
    my_nxt = py_r;
    priority if (ax > MAG_W'(SNAP_HI) && ay < MAG_W'(SNAP_LO)) begin
      my_nxt = '0;
    end else if (ay > MAG_W'(SNAP_HI) && ax < MAG_W'(SNAP_LO)) begin
      mx_nxt = '0;
    end else if (ax > MAG_W'(BOTH_TH) && ay > MAG_W'(BOTH_TH)) begin
      if (ax > ay) begin
        my_nxt = pct_scale30(py_r);
      end else begin
        mx_nxt = pct_scale30(px_r);
      end
    end else begin
      // Neither rule applies, so both percents pass unchanged.
      mx_nxt = px_r;
      my_nxt = py_r;
    end
  end

  // Pulse offset from center: zero inside the dead band, else 5 per percent.
  function automatic logic signed [TW-1:0] pulse_off(input logic signed [PCT_W-1:0] p);
    logic signed [TW-1:0] pe;
    pe = TW'(p);
    if (pct_mag(p) < MAG_W'(NEUTRAL_PCT)) begin
      return '0;
    end
    return TW'(pe * $signed(TW'(PULSE_GAIN)));
  endfunction

  // Move cur toward tgt by at most the slew step.
  function automatic logic [PULSE_BITS-1:0] slew_to(
      input logic [PULSE_BITS-1:0] cur, input logic signed [TW-1:0] tgt,
      input logic [STEP_W-1:0] step);
    logic signed [TW-1:0] d;
    logic signed [TW-1:0] st;
    logic [TW-1:0]        sum;
    st = $signed(TW'(step));
    d  = tgt - $signed({2'b00, cur});
    if (d > st) begin
      d = st;
    end else if (d < -st) begin
      d = -st;
    end
    sum = TW'({2'b00, cur}) + TW'(d);
    return sum[PULSE_BITS-1:0];
  endfunction

  logic signed [TW-1:0] offx, offy, offy_c, tgt_x, tgt_y;

  always_comb begin
    offx   = pulse_off(px_r);
    offy   = pulse_off(py_r);
    offy_c = offy;
    if (offy > $signed(TW'(Y_MAX_OFF))) begin
      offy_c = $signed(TW'(Y_MAX_OFF));
    end else if (offy < -$signed(TW'(Y_MAX_OFF))) begin
      offy_c = -$signed(TW'(Y_MAX_OFF));
    end
    tgt_x = $signed(TW'(PULSE_MID)) + offx;
    tgt_y = $signed(TW'(PULSE_MID)) + $signed(TW'(trim_r)) + offy_c;
  end

  logic in_acc, cfg_wr;

  assign in_acc = in_valid && !in_stall;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      filt_x_r    <= FX_RST;
      filt_y_r    <= FY_RST;
      x_min_r     <= X_MIN_RST;
      x_center_r  <= X_CENTER_RST;
      x_max_r     <= X_MAX_RST;
      y_min_r     <= Y_MIN_RST;
      y_center_r  <= Y_CENTER_RST;
      y_max_r     <= Y_MAX_RST;
      slew_r      <= SLEW_RST;
      trim_r      <= TRIM_W'(TRIM_RST);
    end else begin
      // A new result word is loaded in S_DONE once the output register is
      // free or being emptied in this cycle; otherwise a taken word clears it.
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_X_MIN:    x_min_r    <= cfg_data;
          CFG_X_CENTER: x_center_r <= cfg_data;
          CFG_X_MAX:    x_max_r    <= cfg_data;
          CFG_Y_MIN:    y_min_r    <= cfg_data;
          CFG_Y_CENTER: y_center_r <= cfg_data;
          CFG_Y_MAX:    y_max_r    <= cfg_data;
          CFG_SLEW:     slew_r     <= cfg_data[STEP_W-1:0];
          CFG_TRIM:     trim_r     <= $signed(cfg_data[TRIM_W-1:0]);
          default:      ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            raw_x_r <= in_raw_x;
            raw_y_r <= in_raw_y;
            axis_r  <= 1'b0;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          num_r   <= numer_nxt;
          den_r   <= den_nxt;
          neg_r   <= neg_nxt;
          rem_r   <= '0;
          cnt_r   <= CW'(NUM_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          num_r <= {num_r[NUM_W-2:0], q_bit};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!axis_r) begin
            px_r    <= pct_nxt;
            axis_r  <= 1'b1;
            state_r <= S_SETUP;
          end else begin
            py_r    <= pct_nxt;
            state_r <= S_MIX;
          end
        end
        S_MIX: begin
          px_r    <= mx_nxt;
          py_r    <= my_nxt;
          state_r <= S_SLEW;
        end
        S_SLEW: begin
          filt_x_r <= slew_to(filt_x_r, tgt_x, slew_r);
          filt_y_r <= slew_to(filt_y_r, tgt_y, slew_r);
          state_r  <= S_DONE;
        end
        S_DONE: begin
          // Wait here only while the previous result word is still held.
          if (!out_valid_r || !out_stall) begin
            out_x_pct_r   <= px_r;
            out_y_pct_r   <= py_r;
            out_x_pulse_r <= filt_x_r;
            out_y_pulse_r <= filt_y_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_x_percent = out_x_pct_r;
  assign out_y_percent = out_y_pct_r;
  assign out_x_pulse   = out_x_pulse_r;
  assign out_y_pulse   = out_y_pulse_r;

endmodule

// File: rtl/jts_checker.sv
// Port-level checker for the joystick conditioner, bound to the top level.
`include "joystick_to_servo_conditioner_top_assert.svh"

module jts_checker
  import jts_pkg::*;
#(
  parameter int ADC_BITS   = 12,
  parameter int PULSE_BITS = 11
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [PCT_W-1:0] out_x_percent,
  input logic signed [PCT_W-1:0] out_y_percent,
  input logic [PULSE_BITS-1:0]   out_x_pulse,
  input logic [PULSE_BITS-1:0]   out_y_pulse
);

  logic in_acc;
  logic pct_ok, pulse_ok;

  assign in_acc = in_valid && !in_stall;

  assign pct_ok =
      (out_x_percent >= -$signed(PCT_W'(PCT_FULL))) &&
      (out_x_percent <= $signed(PCT_W'(PCT_FULL))) &&
      (out_y_percent >= -$signed(PCT_W'(PCT_FULL))) &&
      (out_y_percent <= $signed(PCT_W'(PCT_FULL)));

  assign pulse_ok =
      (out_x_pulse >= PULSE_BITS'(PULSE_LO)) && (out_x_pulse <= PULSE_BITS'(PULSE_HI)) &&
      (out_y_pulse >= PULSE_BITS'(PULSE_LO)) && (out_y_pulse <= PULSE_BITS'(PULSE_HI));

  `JTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_x_pulse) && $stable(out_y_pulse) && $stable(out_x_percent) && $stable(out_y_percent), "stalled result word changed")
  `JTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall, "input not stalled after a word was taken")
  `JTS_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid, pct_ok, "percent outside -100..100")
  `JTS_ASSERT_NOW(a_pulse_range, clk, rst_n, out_valid, pulse_ok, "pulse outside servo range")

endmodule

bind joystick_to_servo_conditioner_top jts_checker #(
  .ADC_BITS   (ADC_BITS),
  .PULSE_BITS (PULSE_BITS)
) u_jts_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for the joystick to servo conditioner: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import jts_pkg::*;

  localparam int ADC_W           = 12;
  localparam int PULSE_W         = 11;
  localparam int RAW_MAX         = (1 << ADC_W) - 1;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int NUM_PHASES      = 7;
  localparam int TAIL_CYCLES     = 80;

  // One result word as the block presents it.
  typedef struct packed {
    logic signed [PCT_W-1:0] x_pct;
    logic signed [PCT_W-1:0] y_pct;
    logic [PULSE_W-1:0]      x_pulse;
    logic [PULSE_W-1:0]      y_pulse;
  } servo_word_t;

  // A row of the directed table is either a sample word or a register write.
  typedef enum {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          a;      // raw X, or register index
    int          b;      // raw Y, or register data
    bit          typed;  // result typed in below instead of predicted
    servo_word_t want;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [ADC_W-1:0]        in_raw_x;
  logic [ADC_W-1:0]        in_raw_y;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [PCT_W-1:0] out_x_percent;
  logic signed [PCT_W-1:0] out_y_percent;
  logic [PULSE_W-1:0]      out_x_pulse;
  logic [PULSE_W-1:0]      out_y_pulse;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CAL_W-1:0]        cfg_data;

  joystick_to_servo_conditioner_top #(
    .ADC_BITS  (ADC_W),
    .PULSE_BITS(PULSE_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_raw_x     (in_raw_x),
    .in_raw_y     (in_raw_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x_percent(out_x_percent),
    .out_y_percent(out_y_percent),
    .out_x_pulse  (out_x_pulse),
    .out_y_pulse  (out_y_pulse),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Shadow copy of the calibration registers and the two pulse filters. The
  // filters start at the servo center; Y starts shifted by the reset trim.
  logic [CAL_W-1:0]         x_lo  = X_MIN_RST;
  logic [CAL_W-1:0]         x_mid = X_CENTER_RST;
  logic [CAL_W-1:0]         x_hi  = X_MAX_RST;
  logic [CAL_W-1:0]         y_lo  = Y_MIN_RST;
  logic [CAL_W-1:0]         y_mid = Y_CENTER_RST;
  logic [CAL_W-1:0]         y_hi  = Y_MAX_RST;
  logic [STEP_W-1:0]        step_q = SLEW_RST;
  logic signed [TRIM_W-1:0] trim_q = TRIM_W'(TRIM_RST);
  logic [PULSE_W-1:0]       fx_q = PULSE_W'(PULSE_MID);
  logic [PULSE_W-1:0]       fy_q = PULSE_W'(PULSE_MID + TRIM_RST);

  // Result words predicted for accepted samples, oldest first.
  servo_word_t pending_words[$];
  stim_row_t   dir_rows[$];
  int          errors = 0;

  // Knobs shared between the sender and the receiver process.
  bit rx_idle  = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Signed percent of one axis. The divisor is the half-range on the side of
  // the center where the sample lies, taken as signed even when the
  // calibration is inverted. A zero half-range saturates by the sign of the
  // offset. Integer division truncates toward zero, as the block does.
  function automatic int axis_pct(int raw, int lo, int mid, int hi);
    int d, span, p;
    d    = raw - mid;
    span = (d >= 0) ? hi - mid : mid - lo;
    if (span == 0) p = (d > 0) ? PCT_FULL : ((d < 0) ? -PCT_FULL : 0);
    else p = (d * 100) / span;
    if (p > PCT_FULL) p = PCT_FULL;
    if (p < -PCT_FULL) p = -PCT_FULL;
    return p;
  endfunction

  // Servo pulse for a percent: the dead band gives the center, otherwise the
  // two halves map linearly onto 1000..1500 and 1500..2000.
  function automatic int pct_to_pulse(int p);
    int v;
    if (p > -NEUTRAL_PCT && p < NEUTRAL_PCT) return PULSE_MID;
    if (p < 0) v = (p + 100) * (PULSE_MID - PULSE_LO) / 100 + PULSE_LO;
    else v = p * (PULSE_HI - PULSE_MID) / 100 + PULSE_MID;
    if (v < PULSE_LO) v = PULSE_LO;
    if (v > PULSE_HI) v = PULSE_HI;
    return v;
  endfunction

  // Move a filter toward its target by at most the slew step. A step of zero
  // freezes the filter.
  function automatic logic [PULSE_W-1:0] slew_toward(logic [PULSE_W-1:0] cur, int tgt);
    int d, lim;
    lim = int'(step_q);
    d   = tgt - int'(cur);
    if (d > lim) d = lim;
    else if (d < -lim) d = -lim;
    return PULSE_W'(int'(cur) + d);
  endfunction

  // Full prediction for one sample word; advances the filter copies.
  function automatic servo_word_t next_servo_word(int rx, int ry);
    int x, y, ax, ay, ty, off;
    servo_word_t w;
    x  = axis_pct(rx, x_lo, x_mid, x_hi);
    y  = axis_pct(ry, y_lo, y_mid, y_hi);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    // Cross-axis rule: a strong axis silences a weak one; when both are
    // past the mixing threshold the weaker one is cut to 30 percent, and a
    // tie cuts X.
    if (ax > SNAP_HI && ay < SNAP_LO) y = 0;
    else if (ay > SNAP_HI && ax < SNAP_LO) x = 0;
    else if (ax > BOTH_TH && ay > BOTH_TH) begin
      if (ax > ay) y = (y * 30) / 100;
      else x = (x * 30) / 100;
    end
    fx_q = slew_toward(fx_q, pct_to_pulse(x));
    ty   = pct_to_pulse(y);
    off  = ty - PULSE_MID;
    if (off > Y_MAX_OFF) off = Y_MAX_OFF;
    else if (off < -Y_MAX_OFF) off = -Y_MAX_OFF;
    fy_q = slew_toward(fy_q, PULSE_MID + int'(trim_q) + off);
    w.x_pct   = PCT_W'(x);
    w.y_pct   = PCT_W'(y);
    w.x_pulse = fx_q;
    w.y_pulse = fy_q;
    return w;
  endfunction

  // Gap length in cycles: mostly none, some short, a few percent long.
  function automatic int pick_gap(int long_pct);
    int r;
    r = int'($urandom_range(0, 99));
    if (r < long_pct) return int'($urandom_range(20, 120));
    if (r < 35) return int'($urandom_range(1, 4));
    return 0;
  endfunction

  // Raw sample biased toward the interesting points of the current
  // calibration: the center and its dead band, both ends, the rails.
  function automatic logic [ADC_W-1:0] pick_raw(int lo, int mid, int hi);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, RAW_MAX));
      3, 4:    v = mid + int'($urandom_range(0, 60)) - 30;
      5:       v = lo + int'($urandom_range(0, 20)) - 10;
      6:       v = hi + int'($urandom_range(0, 20)) - 10;
      7:       v = ($urandom_range(0, 1) != 0) ? RAW_MAX : 0;
      default: v = mid + int'($urandom_range(0, 1600)) - 800;
    endcase
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return ADC_W'(v);
  endfunction

  function automatic void add_row(row_kind_t k, int a, int b, bit typed = 1'b0,
                                  int xp = 0, int yp = 0, int xpl = 0, int ypl = 0);
    stim_row_t r;
    r.kind          = k;
    r.a             = a;
    r.b             = b;
    r.typed         = typed;
    r.want.x_pct    = PCT_W'(xp);
    r.want.y_pct    = PCT_W'(yp);
    r.want.x_pulse  = PULSE_W'(xpl);
    r.want.y_pulse  = PULSE_W'(ypl);
    dir_rows.push_back(r);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Offer one sample word at the falling edge and hold it until it is taken.
  // The prediction is made at the accepting edge, so the queue order always
  // follows the acceptance order.
  task automatic push_word(input logic [ADC_W-1:0] rx, input logic [ADC_W-1:0] ry,
                           input bit typed, input servo_word_t want);
    servo_word_t w;
    @(negedge clk);
    in_valid <= 1'b1;
    in_raw_x <= rx;
    in_raw_y <= ry;
    do @(posedge clk); while (in_stall);
    w = next_servo_word(rx, ry);
    pending_words.push_back(typed ? want : w);
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stop offering and wait until every predicted word has come out. Every
  // word yields a result, so the block is idle once the queue is empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Register write; the shadow copy keeps only the bits the register holds.
  task automatic write_reg(input cfg_idx_t idx, input int data);
    logic [CAL_W-1:0] d;
    d = CAL_W'(data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_X_MIN:    x_lo   = d;
      CFG_X_CENTER: x_mid  = d;
      CFG_X_MAX:    x_hi   = d;
      CFG_Y_MIN:    y_lo   = d;
      CFG_Y_CENTER: y_mid  = d;
      CFG_Y_MAX:    y_hi   = d;
      CFG_SLEW:     step_q = d[STEP_W-1:0];
      CFG_TRIM:     trim_q = d[TRIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_axis(input bit is_y, input int lo, input int mid, input int hi);
    if (is_y) begin
      write_reg(CFG_Y_MIN, lo);
      write_reg(CFG_Y_CENTER, mid);
      write_reg(CFG_Y_MAX, hi);
    end else begin
      write_reg(CFG_X_MIN, lo);
      write_reg(CFG_X_CENTER, mid);
      write_reg(CFG_X_MAX, hi);
    end
  endtask

  // Receiver: random stalls while rx_idle is set, and once a long hold-off
  // on request so that the block fills up and has to stall its input.
  initial begin
    int hold_left, stall_left;
    hold_left  = 0;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (rx_idle) stall_left = pick_gap(3);
      end
    end
  end

  // Every taken result word is compared field by field with the oldest
  // prediction. Outputs are read at the rising edge, before the block
  // updates them.
  always @(posedge clk) begin : result_check
    servo_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t mismatch: result word with no prediction pending, %s %0d %0d %0d %0d",
                 $time, "expected none, actual", out_x_percent, out_y_percent,
                 out_x_pulse, out_y_pulse);
      end else begin
        w = pending_words.pop_front();
        check_field("x_percent", $signed(w.x_pct), $signed(out_x_percent));
        check_field("y_percent", $signed(w.y_pct), $signed(out_y_percent));
        check_field("x_pulse", int'(w.x_pulse), int'(out_x_pulse));
        check_field("y_pulse", int'(w.y_pulse), int'(out_y_pulse));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain, verdict.
  initial begin
    int  lo, mid, hi;
    bit  tx_idle;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_raw_x  = '0;
    in_raw_y  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // Directed rows. The first five start from reset and their results can
    // be read off directly: rest, X at both rails, Y at both rails with the
    // Y offset clamp active. The rest are predicted.
    add_row(ROW_WORD, 2000, 2000, 1'b1, 0, 0, 1500, 1450);
    add_row(ROW_WORD, RAW_MAX, 2000, 1'b1, 100, 0, 1530, 1450);
    add_row(ROW_WORD, 0, 2000, 1'b1, -100, 0, 1500, 1450);
    add_row(ROW_WORD, 2000, RAW_MAX, 1'b1, 0, 100, 1500, 1480);
    add_row(ROW_WORD, 2000, 0, 1'b1, 0, -100, 1500, 1450);
    // Both axes saturated: a tie scales X, in both directions.
    add_row(ROW_WORD, RAW_MAX, RAW_MAX);
    add_row(ROW_WORD, 0, 0);
    // Y stronger, then X stronger, with both past the mixing threshold.
    add_row(ROW_WORD, 2660, RAW_MAX);
    add_row(ROW_WORD, RAW_MAX, 2731);
    // Snap thresholds around 70 and 30, and the mixing threshold at 40.
    add_row(ROW_WORD, 2781, 2354);
    add_row(ROW_WORD, 2770, 2354);
    add_row(ROW_WORD, 2781, 2366);
    add_row(ROW_WORD, 2319, 2865);
    add_row(ROW_WORD, 2451, 2500);
    add_row(ROW_WORD, 2440, 2500);
    // Edges of the dead band on both sides.
    add_row(ROW_WORD, 2044, 1920);
    add_row(ROW_WORD, 2055, 1900);
    add_row(ROW_WORD, 1936, 2081);
    // Zero half-range on the positive X side and the negative Y side.
    add_row(ROW_REG, CFG_X_MAX, 2000);
    add_row(ROW_REG, CFG_Y_MIN, 2000);
    add_row(ROW_WORD, 2001, 1999);
    add_row(ROW_WORD, 2000, 2000);
    // Inverted X calibration gives a negative divisor.
    add_row(ROW_REG, CFG_X_MIN, 3000);
    add_row(ROW_WORD, 1000, 2100);
    // A zero slew step freezes both pulses; the widest step lets them jump.
    add_row(ROW_REG, CFG_SLEW, 0);
    add_row(ROW_WORD, RAW_MAX, 0);
    add_row(ROW_REG, CFG_SLEW, 511);
    add_row(ROW_WORD, 0, RAW_MAX);
    // Trim at both extremes only moves later Y targets.
    add_row(ROW_REG, CFG_TRIM, 127);
    add_row(ROW_WORD, 2000, 2000);
    add_row(ROW_REG, CFG_TRIM, -128);
    add_row(ROW_WORD, 2000, RAW_MAX);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(cfg_idx_t'(dir_rows[i].a), dir_rows[i].b);
      end else begin
        push_word(ADC_W'(dir_rows[i].a), ADC_W'(dir_rows[i].b),
                  dir_rows[i].typed, dir_rows[i].want);
        idle_in(pick_gap(5));
      end
    end

    // Random phases, each under its own register setting. All registers are
    // rewritten at the start of every phase.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          // Reset calibration, with the long receiver hold-off while the
          // sender keeps offering back to back.
          write_axis(1'b0, X_MIN_RST, X_CENTER_RST, X_MAX_RST);
          write_axis(1'b1, Y_MIN_RST, Y_CENTER_RST, Y_MAX_RST);
          write_reg(CFG_SLEW, SLEW_RST);
          write_reg(CFG_TRIM, TRIM_RST);
          hold_req = 1'b1;
        end
        2: begin
          // Zero half-ranges: X flat on both sides, Y flat below center.
          mid = int'($urandom_range(0, RAW_MAX));
          write_axis(1'b0, mid, mid, mid);
          mid = int'($urandom_range(0, RAW_MAX));
          write_axis(1'b1, mid, mid, int'($urandom_range(mid, RAW_MAX)));
          write_reg(CFG_SLEW, 500);
          write_reg(CFG_TRIM, 100);
        end
        3: begin
          // Inverted calibration on both axes.
          for (int ax = 0; ax < 2; ax++) begin
            mid = int'($urandom_range(1000, 3000));
            write_axis(ax[0], int'($urandom_range(mid, RAW_MAX)), mid,
                       int'($urandom_range(0, mid)));
          end
          write_reg(CFG_SLEW, 1);
          write_reg(CFG_TRIM, -100);
        end
        4: begin
          // Anything the register bits allow, including unused upper data bits.
          for (int ax = 0; ax < 2; ax++)
            write_axis(ax[0], int'($urandom_range(0, RAW_MAX)),
                       int'($urandom_range(0, RAW_MAX)), int'($urandom_range(0, RAW_MAX)));
          write_reg(CFG_SLEW, int'($urandom_range(0, RAW_MAX)));
          write_reg(CFG_TRIM, int'($urandom_range(0, RAW_MAX)));
        end
        5: begin
          // Calibration at the rails, widest step, most negative trim.
          write_axis(1'b0, 0, 0, RAW_MAX);
          write_axis(1'b1, 0, RAW_MAX, RAW_MAX);
          write_reg(CFG_SLEW, 511);
          write_reg(CFG_TRIM, -128);
        end
        default: begin
          // Plausible random calibration.
          for (int ax = 0; ax < 2; ax++) begin
            mid = int'($urandom_range(1500, 2500));
            lo  = int'($urandom_range(0, mid));
            hi  = int'($urandom_range(mid, RAW_MAX));
            write_axis(ax[0], lo, mid, hi);
          end
          write_reg(CFG_SLEW, int'($urandom_range(1, 500)));
          write_reg(CFG_TRIM, int'($urandom_range(0, 200)) - 100);
        end
      endcase
      // Phase 0 keeps the sender busy against the hold-off, phase 6 runs
      // with no idling on either side, phase 5 only idles the sender.
      tx_idle = (ph != 0) && (ph != 6);
      rx_idle = (ph != 5) && (ph != 6);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        push_word(pick_raw(x_lo, x_mid, x_hi), pick_raw(y_lo, y_mid, y_hi), 1'b0, '0);
        if (tx_idle) idle_in(pick_gap(5));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
